// ===== rtl/core/three_key_menu_controller_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the three-key menu controller
// Property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef THREE_KEY_MENU_CONTROLLER_UNIT_DEFINES_SVH
`define THREE_KEY_MENU_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKMC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tkmc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TKMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tkmc assertion failed");

`endif

// ===== rtl/core/tkmc_pkg.sv =====
// ---------------------------------------------------------------------------
// Three-key menu controller package
// Payload types, codes, limits and the wrap-adjust helper.
// ---------------------------------------------------------------------------
package tkmc_pkg;

    localparam int COLOR_COUNT = 8;
    localparam int LEVEL_COUNT = 6;

    localparam int KEY_COUNT = 3;
    localparam int SINCE_W   = 11;
    localparam int CHANGE_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [6:0] COLOR_LIMIT  = 7'(COLOR_COUNT);
    localparam logic [2:0] LEVEL_MAX    = 3'(LEVEL_COUNT - 1);
    localparam logic [6:0] MINSEC_LIMIT = 7'd60;
    localparam logic [6:0] HOUR_LIMIT   = 7'd24;

    localparam logic [SINCE_W-1:0]  PRESS_GAP_RESET  = 11'd200;
    localparam logic [SINCE_W-1:0]  HOLD_TIME_RESET  = 11'd1000;
    localparam logic [CHANGE_W-1:0] SAVE_DELAY_RESET = 12'd2000;

    // Key positions in key_levels
    localparam int KEY_SELECT = 0;
    localparam int KEY_DOWN   = 1;
    localparam int KEY_UP     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_GAP  = 2'd0,
        CFG_HOLD_TIME  = 2'd1,
        CFG_SAVE_DELAY = 2'd2
    } tkmc_cfg_idx_t;

    localparam logic MODE_SETTINGS = 1'b0;
    localparam logic MODE_TIME     = 1'b1;

    localparam logic [1:0] SUB_COLOR  = 2'd0;
    localparam logic [1:0] SUB_LEVEL  = 2'd1;
    localparam logic [1:0] SUB_ORIENT = 2'd2;
    localparam logic [1:0] SUB_SECOND = 2'd0;
    localparam logic [1:0] SUB_MINUTE = 2'd1;
    localparam logic [1:0] SUB_HOUR   = 2'd2;
    localparam logic [1:0] SUB_LAST   = 2'd2;

    typedef struct packed {
        logic [2:0] key_levels;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
    } tkmc_in_t;

    typedef struct packed {
        logic [2:0] color_index;
        logic [2:0] brightness_index;
        logic       is_rotated;
        logic       menu_mode;
        logic [1:0] sub_item;
        logic [4:0] edit_hour;
        logic [5:0] edit_minute;
        logic [5:0] edit_second;
        logic       set_time_strobe;
        logic       save_strobe;
        logic [7:0] settings_byte;
    } tkmc_out_t;

    typedef struct packed {
        logic press;
        logic hold;
    } tkmc_key_evt_t;

    // Step a value up or down, wrapping within [0, limit). An up step from a
    // value at or past the limit lands on zero.
    function automatic logic [5:0] tkmc_wrap(input logic [5:0] value,
                                             input logic [6:0] limit,
                                             input logic       up);
        logic [6:0] inc;
        logic [5:0] result;
        inc = {1'b0, value} + 7'd1;
        if (up) begin
            result = (inc >= limit) ? 6'd0 : inc[5:0];
        end else begin
            result = (value == 6'd0) ? 6'(limit - 7'd1) : value - 6'd1;
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/three_key_menu_controller_unit.sv =====
// ---------------------------------------------------------------------------
// Three-key menu controller
// Menu, minus and plus key handling for display settings and time edit.
// ---------------------------------------------------------------------------
// Each input transaction on s_data is one millisecond tick carrying the three
// active-low key levels and the current clock time. Every accepted tick gives
// exactly one result transaction on m_data, carrying the display settings,
// the menu position, the edited time and the set-time and save strobes.
// The configuration channel (cfg_index, cfg_wdata) sets the press gap, the
// hold time and the save delay; it is always ready and should only be
// written while no tick is in flight. Writes to an unused index are ignored.
// A tick is presented on m_data in the cycle after it is accepted.
// Throughput is one tick per cycle while results are taken, set by the single
// result register that all key, menu and save logic feeds.
// While the result register is full and m_ready is low, s_ready drops and
// the result is held; it rises again on the cycle the result is taken.
// Synchronous reset restores the default timings, clears all settings, the
// edit time and the elapsed counters, and treats every key as released.
// ---------------------------------------------------------------------------
module three_key_menu_controller_unit
    import tkmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tkmc_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tkmc_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                accept;
    tkmc_key_evt_t       evt [KEY_COUNT];

    logic [SINCE_W-1:0]  press_gap_reg;
    logic [SINCE_W-1:0]  hold_time_reg;
    logic [CHANGE_W-1:0] save_delay_reg;

    logic [2:0]          color_reg, color_next;
    logic [2:0]          level_reg, level_next;
    logic                rotated_reg, rotated_next;
    logic                mode_reg, mode_next;
    logic [1:0]          item_reg, item_next;
    logic [4:0]          hour_reg, hour_next;
    logic [5:0]          minute_reg, minute_next;
    logic [5:0]          second_reg, second_next;
    logic                unsaved_reg, unsaved_next;
    logic [CHANGE_W-1:0] since_change_reg, since_change_next;
    logic                set_time;
    logic                save;

    logic                m_valid_reg;
    tkmc_out_t           m_data_reg;
    tkmc_out_t           result;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        tkmc_key_timer u_key_timer (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .accept    (accept),
            .level     (s_data.key_levels[k]),
            .press_gap (press_gap_reg),
            .hold_time (hold_time_reg),
            .evt       (evt[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_gap_reg  <= PRESS_GAP_RESET;
            hold_time_reg  <= HOLD_TIME_RESET;
            save_delay_reg <= SAVE_DELAY_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PRESS_GAP:  press_gap_reg  <= cfg_wdata[SINCE_W-1:0];
                CFG_HOLD_TIME:  hold_time_reg  <= cfg_wdata[SINCE_W-1:0];
                CFG_SAVE_DELAY: save_delay_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Keys take effect in the order menu, minus, plus; each sees the state
    // left by the one before it.
    always_comb begin
        color_next   = color_reg;
        level_next   = level_reg;
        rotated_next = rotated_reg;
        mode_next    = mode_reg;
        item_next    = item_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        unsaved_next = unsaved_reg;
        set_time     = 1'b0;
        since_change_next = (since_change_reg == {CHANGE_W{1'b1}}) ?
                            since_change_reg : since_change_reg + 1'b1;

        if (evt[KEY_SELECT].press) begin
            item_next = (item_next >= SUB_LAST) ? 2'd0 : item_next + 2'd1;
        end
        if (evt[KEY_SELECT].hold) begin
            if (mode_next == MODE_SETTINGS) begin
                mode_next   = MODE_TIME;
                hour_next   = s_data.now_hour;
                minute_next = s_data.now_minute;
                second_next = s_data.now_second;
                item_next   = SUB_SECOND;
            end else begin
                mode_next = MODE_SETTINGS;
                set_time  = 1'b1;
            end
        end

        for (int k = KEY_DOWN; k <= KEY_UP; k++) begin
            if (evt[k].press) begin
                if (mode_next == MODE_SETTINGS) begin
                    case (item_next)
                        SUB_COLOR: color_next =
                            3'(tkmc_wrap({3'b000, color_next}, COLOR_LIMIT, k == KEY_UP));
                        SUB_LEVEL: begin
                            if (k == KEY_UP) begin
                                if (level_next < LEVEL_MAX) level_next = level_next + 3'd1;
                            end else if (level_next != 3'd0) begin
                                level_next = level_next - 3'd1;
                            end
                        end
                        SUB_ORIENT: rotated_next = !rotated_next;
                        default: ;
                    endcase
                    unsaved_next      = 1'b1;
                    since_change_next = '0;
                end else begin
                    case (item_next)
                        SUB_SECOND: second_next =
                            tkmc_wrap(second_next, MINSEC_LIMIT, k == KEY_UP);
                        SUB_MINUTE: minute_next =
                            tkmc_wrap(minute_next, MINSEC_LIMIT, k == KEY_UP);
                        SUB_HOUR: hour_next =
                            5'(tkmc_wrap({1'b0, hour_next}, HOUR_LIMIT, k == KEY_UP));
                        default: ;
                    endcase
                end
            end
        end

        save = unsaved_next && (since_change_next > save_delay_reg);
        if (save) begin
            unsaved_next = 1'b0;
        end

        result.color_index      = color_next;
        result.brightness_index = level_next;
        result.is_rotated       = rotated_next;
        result.menu_mode        = mode_next;
        result.sub_item         = item_next;
        result.edit_hour        = hour_next;
        result.edit_minute      = minute_next;
        result.edit_second      = second_next;
        result.set_time_strobe  = set_time;
        result.save_strobe      = save;
        result.settings_byte    = save ? {1'b0, color_next, level_next, rotated_next} : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg        <= '0;
            level_reg        <= '0;
            rotated_reg      <= 1'b0;
            mode_reg         <= MODE_SETTINGS;
            item_reg         <= '0;
            hour_reg         <= '0;
            minute_reg       <= '0;
            second_reg       <= '0;
            unsaved_reg      <= 1'b0;
            since_change_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                color_reg        <= color_next;
                level_reg        <= level_next;
                rotated_reg      <= rotated_next;
                mode_reg         <= mode_next;
                item_reg         <= item_next;
                hour_reg         <= hour_next;
                minute_reg       <= minute_next;
                second_reg       <= second_next;
                unsaved_reg      <= unsaved_next;
                since_change_reg <= since_change_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/tkmc_key_timer.sv =====
// ---------------------------------------------------------------------------
// Key timer
// Edge detection, press rate limiting and hold detection for one key.
// ---------------------------------------------------------------------------
module tkmc_key_timer
    import tkmc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               level,
    input  logic [SINCE_W-1:0] press_gap,
    input  logic [SINCE_W-1:0] hold_time,
    output tkmc_key_evt_t      evt
);

    logic               level_prev_reg;
    logic               armed_reg;
    logic               armed_next;
    logic [SINCE_W-1:0] since_reg;
    logic [SINCE_W-1:0] since_inc;
    logic [SINCE_W-1:0] since_next;

    always_comb begin
        since_inc = (since_reg == {SINCE_W{1'b1}}) ? since_reg : since_reg + 1'b1;
        evt.press = !level && level_prev_reg && (since_inc > press_gap);
        // A press restarts the count, so a hold cannot fire on the same tick.
        evt.hold  = !level && armed_reg && !evt.press && (since_inc > hold_time);
        since_next = (evt.press || evt.hold) ? '0 : since_inc;
        if (level) begin
            armed_next = 1'b0;
        end else if (evt.press) begin
            armed_next = 1'b1;
        end else if (evt.hold) begin
            armed_next = 1'b0;
        end else begin
            armed_next = armed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_prev_reg <= 1'b1;
            armed_reg      <= 1'b0;
            since_reg      <= '0;
        end else if (accept) begin
            level_prev_reg <= level;
            armed_reg      <= armed_next;
            since_reg      <= since_next;
        end
    end

endmodule

// ===== rtl/core/tkmc_checker.sv =====
// ---------------------------------------------------------------------------
// Three-key menu controller checker
// Port-level properties of the controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "three_key_menu_controller_unit_defines.svh"

module tkmc_checker
    import tkmc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input tkmc_out_t m_data
);

    // A stalled result transaction stays put.
    `TKMC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Every accepted tick is presented on the next cycle.
    `TKMC_ASSERT_NEXT(a_tick_result, aclk, aresetn, s_valid && s_ready, m_valid)

    // The packed byte is only driven on a save tick.
    `TKMC_ASSERT_NOW(a_byte_quiet, aclk, aresetn, m_valid && !m_data.save_strobe, m_data.settings_byte == 8'd0)

    // Committing the edited time returns to the settings menu.
    `TKMC_ASSERT_NOW(a_commit_mode, aclk, aresetn, m_valid && m_data.set_time_strobe, m_data.menu_mode == MODE_SETTINGS)

    // The sub-item cycles over three positions only.
    `TKMC_ASSERT_NOW(a_sub_range, aclk, aresetn, m_valid, m_data.sub_item != 2'd3)

endmodule

bind three_key_menu_controller_unit tkmc_checker u_tkmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== test/menu_result_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result checker for the three-key menu controller
// Watches the tick, result and register channels, keeps its own copy of the
// menu state, predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module menu_result_checker
    import tkmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  tkmc_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  tkmc_out_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    failures,
    output int                    in_flight,
    output int                    ticks_checked,
    output int                    presses_seen,
    output int                    holds_seen,
    output int                    commits_seen,
    output int                    saves_seen
);

    localparam logic [SINCE_W-1:0]  KEY_AGE_MAX    = '1;
    localparam logic [CHANGE_W-1:0] CHANGE_AGE_MAX = '1;

    logic [SINCE_W-1:0]   gap_ms;
    logic [SINCE_W-1:0]   hold_ms;
    logic [CHANGE_W-1:0]  save_ms;

    logic [KEY_COUNT-1:0] last_levels;
    logic [KEY_COUNT-1:0] hold_pending;
    logic [SINCE_W-1:0]   key_age [KEY_COUNT];
    logic [2:0]           colour;
    logic [2:0]           level;
    logic                 rotated;
    logic                 edit_mode;
    logic [1:0]           item;
    logic [4:0]           edit_h;
    logic [5:0]           edit_m;
    logic [5:0]           edit_s;
    logic                 dirty;
    logic [CHANGE_W-1:0]  change_age;
    logic                 commit_now;

    tkmc_out_t predicted_results [$];

    // Up wraps to zero on reaching the limit (also from an out-of-range
    // value); down from zero lands on the limit minus one.
    function automatic logic [5:0] wrap_step(input int value, input int limit,
                                             input int mask, input logic up);
        int n;
        n = (value + 1) & mask;
        if (up) return (n >= limit) ? 6'd0 : 6'(n);
        else return (value == 0) ? 6'(limit - 1) : 6'(value - 1);
    endfunction

    task automatic clear_model();
        gap_ms       = PRESS_GAP_RESET;
        hold_ms      = HOLD_TIME_RESET;
        save_ms      = SAVE_DELAY_RESET;
        last_levels  = '1;
        hold_pending = '0;
        for (int k = 0; k < KEY_COUNT; k++) key_age[k] = '0;
        colour     = '0;
        level      = '0;
        rotated    = 1'b0;
        edit_mode  = MODE_SETTINGS;
        item       = '0;
        edit_h     = '0;
        edit_m     = '0;
        edit_s     = '0;
        dirty      = 1'b0;
        change_age = '0;
        commit_now = 1'b0;
        predicted_results.delete();
    endtask

    task automatic apply_press(input int k);
        logic up;
        up = (k == KEY_UP);
        presses_seen++;
        if (k == KEY_SELECT) begin
            item = (item >= SUB_LAST) ? '0 : item + 2'd1;
        end else if (edit_mode == MODE_SETTINGS) begin
            case (item)
                SUB_COLOR:  colour = 3'(wrap_step(colour, COLOR_COUNT, 'h1F, up));
                SUB_LEVEL: begin
                    if (up) begin
                        if (level < LEVEL_MAX) level = level + 3'd1;
                    end else if (level != '0) begin
                        level = level - 3'd1;
                    end
                end
                SUB_ORIENT: rotated = ~rotated;
                default: ;
            endcase
            // Any adjustment in the settings menu restarts the save delay.
            dirty      = 1'b1;
            change_age = '0;
        end else begin
            case (item)
                SUB_SECOND: edit_s = wrap_step(edit_s, MINSEC_LIMIT, 'h3F, up);
                SUB_MINUTE: edit_m = wrap_step(edit_m, MINSEC_LIMIT, 'h3F, up);
                SUB_HOUR:   edit_h = 5'(wrap_step(edit_h, HOUR_LIMIT, 'h1F, up));
                default: ;
            endcase
        end
    endtask

    task automatic apply_hold(input int k, input tkmc_in_t tick);
        holds_seen++;
        if (k == KEY_SELECT) begin
            if (edit_mode == MODE_SETTINGS) begin
                edit_mode = MODE_TIME;
                edit_h    = tick.now_hour;
                edit_m    = tick.now_minute;
                edit_s    = tick.now_second;
                item      = '0;
            end else begin
                edit_mode  = MODE_SETTINGS;
                commit_now = 1'b1;
                commits_seen++;
            end
        end
    endtask

    task automatic advance_menu_tick(input tkmc_in_t tick, output tkmc_out_t res);
        logic down;
        commit_now = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++)
            if (key_age[k] != KEY_AGE_MAX) key_age[k] = key_age[k] + 1'b1;
        if (change_age != CHANGE_AGE_MAX) change_age = change_age + 1'b1;

        // Keys in order menu, minus, plus; each sees what the earlier did.
        for (int k = 0; k < KEY_COUNT; k++) begin
            down = ~tick.key_levels[k];
            if (down && last_levels[k] && key_age[k] > gap_ms) begin
                apply_press(k);
                hold_pending[k] = 1'b1;
                key_age[k]      = '0;
            end
            if (down && hold_pending[k] && key_age[k] > hold_ms) begin
                key_age[k] = '0;
                apply_hold(k, tick);
                hold_pending[k] = 1'b0;
            end
            if (!down) hold_pending[k] = 1'b0;
        end
        last_levels = tick.key_levels;

        res = '0;
        if (dirty && change_age > save_ms) begin
            dirty             = 1'b0;
            res.save_strobe   = 1'b1;
            res.settings_byte = {1'b0, colour, level, rotated};
            saves_seen++;
        end
        res.color_index      = colour;
        res.brightness_index = level;
        res.is_rotated       = rotated;
        res.menu_mode        = edit_mode;
        res.sub_item         = item;
        res.edit_hour        = edit_h;
        res.edit_minute      = edit_m;
        res.edit_second      = edit_s;
        res.set_time_strobe  = commit_now;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            if (failures < 10)
                $display("tick %0d: %s expected %0d, got %0d", ticks_checked, name,
                         want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        tkmc_out_t want;
        tkmc_out_t fresh;
        if (!aresetn) begin
            clear_model();
            in_flight <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PRESS_GAP:  gap_ms  = cfg_wdata[SINCE_W-1:0];
                    CFG_HOLD_TIME:  hold_ms = cfg_wdata[SINCE_W-1:0];
                    CFG_SAVE_DELAY: save_ms = cfg_wdata[CHANGE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    if (failures < 10)
                        $display("result transaction with no tick outstanding");
                    failures++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("color_index", want.color_index, m_data.color_index);
                    check_field("brightness_index", want.brightness_index,
                                m_data.brightness_index);
                    check_field("is_rotated", want.is_rotated, m_data.is_rotated);
                    check_field("menu_mode", want.menu_mode, m_data.menu_mode);
                    check_field("sub_item", want.sub_item, m_data.sub_item);
                    check_field("edit_hour", want.edit_hour, m_data.edit_hour);
                    check_field("edit_minute", want.edit_minute, m_data.edit_minute);
                    check_field("edit_second", want.edit_second, m_data.edit_second);
                    check_field("set_time_strobe", want.set_time_strobe,
                                m_data.set_time_strobe);
                    check_field("save_strobe", want.save_strobe, m_data.save_strobe);
                    check_field("settings_byte", want.settings_byte,
                                m_data.settings_byte);
                    ticks_checked++;
                end
            end
            if (s_valid && s_ready) begin
                advance_menu_tick(s_data, fresh);
                predicted_results.push_back(fresh);
            end
            in_flight <= predicted_results.size();
        end
    end

endmodule

// ===== test/three_key_menu_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the three-key menu controller
// Drives millisecond ticks made of key gestures (taps, holds, chords, noise)
// under a sweep of press gap, hold time and save delay settings, with random
// idling on both channels; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module three_key_menu_controller_unit_tb;
    import tkmc_pkg::*;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int LONG_STALL_CYCLES = 120;
    localparam logic [2:0] KEYS_RELEASED = 3'b111;
    // Opening sequence of key levels, first tick in the top bits.
    localparam logic [71:0] OPENING_KEYS = {
        3'd7, 3'd3, 3'd7, 3'd5, 3'd7, 3'd5, 3'd6, 3'd7, 3'd3, 3'd1, 3'd7, 3'd6,
        3'd3, 3'd7, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd3, 3'd7, 3'd5};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tkmc_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    tkmc_out_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int failures;
    int in_flight;
    int ticks_checked;
    int presses_seen;
    int holds_seen;
    int commits_seen;
    int saves_seen;

    int cur_gap;
    int cur_hold;
    int ticks_sent     = 0;
    bit sender_jitter  = 1'b1;
    bit ready_jitter   = 1'b1;
    bit stall_wanted   = 1'b0;
    bit stall_served   = 1'b0;

    always #5 aclk = ~aclk;

    three_key_menu_controller_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    menu_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .failures      (failures),
        .in_flight     (in_flight),
        .ticks_checked (ticks_checked),
        .presses_seen  (presses_seen),
        .holds_seen    (holds_seen),
        .commits_seen  (commits_seen),
        .saves_seen    (saves_seen)
    );

    // Result side: short random stalls, and once a long one so that the
    // block fills up and holds off the tick channel.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_wanted && !stall_served) begin
                m_ready <= 1'b0;
                stall_served = 1'b1;
                repeat (LONG_STALL_CYCLES) @(posedge aclk);
            end else if (ready_jitter && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly a valid time of day, now and then a field above its limit.
    function automatic tkmc_in_t random_clock(input logic [2:0] levels);
        tkmc_in_t t;
        t.key_levels = levels;
        t.now_hour   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                                   : 5'($urandom_range(0, 23));
        t.now_minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                                   : 6'($urandom_range(0, 59));
        t.now_second = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                                   : 6'($urandom_range(0, 59));
        return t;
    endfunction

    // Called at a rising edge; returns at the edge where the tick is taken.
    task automatic send_tick(input tkmc_in_t tick);
        if (sender_jitter && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= tick;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    task automatic hold_levels(input logic [2:0] levels, input int count);
        repeat (count) send_tick(random_clock(levels));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] gap,
                             input logic [CFG_DATA_W-1:0] hold,
                             input logic [CFG_DATA_W-1:0] save,
                             input bit touch_spare);
        wait_idle();
        if (touch_spare) put_reg(CFG_SPARE_IDX, 12'($urandom()));
        put_reg(CFG_PRESS_GAP, gap);
        put_reg(CFG_HOLD_TIME, hold);
        put_reg(CFG_SAVE_DELAY, save);
        cfg_valid <= 1'b0;
        cur_gap  = gap[SINCE_W-1:0];
        cur_hold = hold[SINCE_W-1:0];
    endtask

    // Key gestures with random clock content until the tick budget is spent.
    task automatic run_gestures(input int budget);
        int stop_at;
        int pick;
        int k;
        int span;
        logic [2:0] lv;
        stop_at = ticks_sent + budget;
        while (ticks_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            k    = $urandom_range(0, KEY_COUNT - 1);
            lv   = KEYS_RELEASED;
            if (pick < 13) begin
                // Taps stay short of the hold time; long presses pass it.
                if (pick >= 10 && $urandom_range(0, 2) != 0) k = KEY_SELECT;
                lv[k] = 1'b0;
                span = (pick < 10) ? $urandom_range(1, cur_hold + 1)
                                   : cur_hold + $urandom_range(2, 5);
                hold_levels(lv, span);
                hold_levels(KEYS_RELEASED, $urandom_range(1, cur_gap + 3));
            end else if (pick < 15) begin
                lv = 3'($urandom_range(0, 7));
                lv[k] = 1'b0;
                lv[(k + 1) % KEY_COUNT] = 1'b0;
                hold_levels(lv, $urandom_range(1, 4));
            end else if (pick < 17) begin
                repeat ($urandom_range(1, 6)) hold_levels(3'($urandom_range(0, 7)), 1);
            end else begin
                hold_levels(KEYS_RELEASED, $urandom_range(1, 8));
            end
        end
    endtask

    initial begin
        tkmc_in_t tick;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Default timings straight after reset: presses this early are too
        // soon after reset and must be ignored.
        tick = '0;
        send_tick(tick);
        tick.key_levels = KEYS_RELEASED;
        send_tick(tick);

        // Upper data bit set on the 11-bit registers: it must be dropped.
        configure(12'h800, 12'h804, 12'd2, 1'b0);
        // Colour up, down and a wrap below zero, level up and down, rotation, sub-item cycle,
        // then a menu hold that copies an out-of-range clock into time edit.
        tick = '1;
        for (int i = 0; i < 24; i++) begin
            tick.key_levels = OPENING_KEYS[3 * (23 - i) +: 3];
            send_tick(tick);
        end
        run_gestures(240);

        configure(12'($urandom_range(1, 6)), 12'd0, 12'd0, 1'b0);
        run_gestures(180);

        configure(12'($urandom_range(0, 5)), 12'($urandom_range(2, 10)),
                  12'($urandom_range(1, 30)), 1'b0);
        stall_wanted = 1'b1;
        run_gestures(240);

        // Largest timings: a press this soon after the previous one of the
        // same key is refused.
        configure(12'd2046, 12'd2046, 12'd4094, 1'b1);
        hold_levels(KEYS_RELEASED, 30);
        hold_levels(3'b011, 1);
        hold_levels(KEYS_RELEASED, 4);

        configure(12'($urandom_range(7, 12)), 12'($urandom_range(10, 20)),
                  12'($urandom_range(100, 400)), 1'b0);
        run_gestures(180);

        sender_jitter = 1'b0;
        ready_jitter  = 1'b0;
        configure(12'($urandom_range(0, 3)), 12'($urandom_range(3, 8)),
                  12'($urandom_range(0, 10)), 1'b0);
        run_gestures(240);

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Checked %0d ticks: %0d presses, %0d holds, %0d time commits, %0d saves.",
                 ticks_checked, presses_seen, holds_seen, commits_seen, saves_seen);
        $display("Timings swept from zero to the largest values, with a long result stall.");
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
